### src/debt_graph_max_flow_simplifier_macros.svh
// Assertion macros shared by the debt graph simplifier RTL.
`ifndef DEBT_GRAPH_MAX_FLOW_SIMPLIFIER_MACROS_SVH
`define DEBT_GRAPH_MAX_FLOW_SIMPLIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DGMF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DGMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dgmf_pkg.sv
// Types and constants of the debt graph simplifier.
package dgmf_pkg;

    localparam int unsigned CMD_W     = 1;
    localparam int unsigned MEMBER_W  = 3;
    localparam int unsigned ADD_AMT_W = 16;
    localparam int unsigned SETTLE_W  = 24;
    localparam int unsigned MCOUNT_W  = 4;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_ADD      = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SIMPLIFY = 1'b1;

    // Register index taken from paddr[2].
    localparam logic REG_MEMBER_COUNT = 1'b0;

    localparam logic [MCOUNT_W-1:0] MCOUNT_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_PAIR,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_RD,
        ST_BFS_CHK,
        ST_TR_RD,
        ST_TR_WR,
        ST_WR_TOTAL,
        ST_EM_RD,
        ST_EM_SEND
    } state_t;

endpackage

### src/dgmf_in_if.sv
// Input channel carrying add and simplify commands.
interface dgmf_in_if;
    import dgmf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [MEMBER_W-1:0]  from_member;
    logic [MEMBER_W-1:0]  to_member;
    logic [ADD_AMT_W-1:0] amount;

    modport source (output valid, cmd, from_member, to_member, amount, input ready);
    modport sink (input valid, cmd, from_member, to_member, amount, output ready);
endinterface

### src/dgmf_out_if.sv
// Output channel carrying the entries of the simplified matrix.
interface dgmf_out_if;
    import dgmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [MEMBER_W-1:0] payer;
    logic [MEMBER_W-1:0] payee;
    logic [SETTLE_W-1:0] settle_amount;
    logic                last;

    modport source (output valid, payer, payee, settle_amount, last, input ready);
    modport sink (input valid, payer, payee, settle_amount, last, output ready);
endinterface

### src/debt_graph_max_flow_simplifier.sv
// Debt ledger with a max-flow simplifier driven by a single-port work matrix sequencer.
//
// An add word runs a ledger read, then a saturating write back, and the input is held
// off meanwhile. A simplify word first copies the ledger to the work matrix, reading
// and then writing each of the MAX_MEMBERS^2 cells, then for each ordered pair runs
// breadth-first searches where each search makes one registered read per neighbour
// probe plus a read and a write per path edge on traceback, and finally emits n*n words,
// holding each word while the output stalls. The run time is set by the single read
// port of the work matrix: every probe of an edge is one registered read.
module debt_graph_max_flow_simplifier #(
    parameter int unsigned MAX_MEMBERS = 8,
    parameter int unsigned AMOUNT_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dgmf_pkg::PADDR_W-1:0]     paddr,
    input  logic [dgmf_pkg::PDATA_W-1:0]     pwdata,
    output logic [dgmf_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    dgmf_in_if.sink                          in_ch,
    dgmf_out_if.source                       out_ch
);
    import dgmf_pkg::*;
    `include "debt_graph_max_flow_simplifier_macros.svh"

    localparam int unsigned IDX_BITS  = $clog2(MAX_MEMBERS);
    localparam int unsigned CNT_BITS  = $clog2(MAX_MEMBERS + 1);
    localparam int unsigned CELLS     = MAX_MEMBERS * MAX_MEMBERS;
    localparam int unsigned CELL_BITS = $clog2(CELLS);
    localparam int unsigned LSUM_W    = ((AMOUNT_BITS > ADD_AMT_W) ? AMOUNT_BITS : ADD_AMT_W) + 1;

    localparam logic [AMOUNT_BITS-1:0] AMT_MAX = {AMOUNT_BITS{1'b1}};

    function automatic logic [CELL_BITS-1:0] cell_at(
        input logic [IDX_BITS-1:0] row,
        input logic [IDX_BITS-1:0] col
    );
        logic [CELL_BITS-1:0] base;
        base = CELL_BITS'(row) * CELL_BITS'(MAX_MEMBERS);
        return base + CELL_BITS'(col);
    endfunction

    // Memories.
    logic [AMOUNT_BITS-1:0] ledger_mem [CELLS];
    logic [AMOUNT_BITS-1:0] work_mem [CELLS];
    logic [AMOUNT_BITS-1:0] led_rdata;
    logic [AMOUNT_BITS-1:0] wk_rdata;
    logic [CELL_BITS-1:0]   led_raddr, led_waddr, wk_raddr, wk_waddr;
    logic [AMOUNT_BITS-1:0] led_wdata, wk_wdata;
    logic                   led_we, wk_we;

    // Control and datapath registers.
    state_t                 state_reg, state_next;
    logic [MCOUNT_W-1:0]    mcount_reg;
    logic [CELLS-1:0]       lvalid_reg, lvalid_next;
    logic [CELL_BITS-1:0]   cell_reg, cell_next;
    logic [ADD_AMT_W-1:0]   amt_reg, amt_next;
    logic [IDX_BITS-1:0]    i_reg, i_next, j_reg, j_next;
    logic [IDX_BITS-1:0]    u_reg, u_next, v_reg, v_next, pu_reg, pu_next;
    logic [CNT_BITS-1:0]    k_reg, k_next, head_reg, head_next, tail_reg, tail_next;
    logic [AMOUNT_BITS-1:0] cap_reg, cap_next, bott_reg, bott_next, total_reg, total_next;
    logic [MAX_MEMBERS-1:0] visited_reg, visited_next;
    logic [IDX_BITS-1:0]    parent_reg [MAX_MEMBERS];
    logic [IDX_BITS-1:0]    parent_next [MAX_MEMBERS];
    logic [IDX_BITS-1:0]    qnode_reg [MAX_MEMBERS];
    logic [IDX_BITS-1:0]    qnode_next [MAX_MEMBERS];
    logic [AMOUNT_BITS-1:0] qcap_reg [MAX_MEMBERS];
    logic [AMOUNT_BITS-1:0] qcap_next [MAX_MEMBERS];

    logic [CNT_BITS-1:0]    n_eff;
    logic [IDX_BITS-1:0]    n_last, kidx;
    logic                   pair_end, i_end;
    logic [LSUM_W-1:0]      led_sum;
    logic [AMOUNT_BITS:0]   flow_sum;
    logic [AMOUNT_BITS-1:0] led_cur, edge_min;
    logic [AMOUNT_BITS+SETTLE_W-1:0] settle_wide;

    // Configuration port.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MEMBER_COUNT);
    assign prdata = (paddr[2] == REG_MEMBER_COUNT) ? PDATA_W'(mcount_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcount_reg <= MCOUNT_RESET;
        end
        else if (cfg_wr)
        begin
            mcount_reg <= pwdata[MCOUNT_W-1:0];
        end
    end

    // Effective member count clamped to the range 2 to MAX_MEMBERS.
    always_comb
    begin
        if (mcount_reg < MCOUNT_W'(2))
        begin
            n_eff = CNT_BITS'(2);
        end
        else if ({1'b0, mcount_reg} > (MCOUNT_W + 1)'(MAX_MEMBERS))
        begin
            n_eff = CNT_BITS'(MAX_MEMBERS);
        end
        else
        begin
            n_eff = CNT_BITS'(mcount_reg);
        end
    end
    assign n_last   = IDX_BITS'(n_eff - CNT_BITS'(1));
    assign kidx     = k_reg[IDX_BITS-1:0];
    assign i_end    = (i_reg == n_last);
    assign pair_end = i_end && (j_reg == n_last);

    assign led_cur  = lvalid_reg[cell_reg] ? led_rdata : '0;
    assign led_sum  = LSUM_W'(led_cur) + LSUM_W'(amt_reg);
    assign flow_sum = {1'b0, total_reg} + {1'b0, edge_min};
    assign edge_min = (wk_rdata < cap_reg) ? wk_rdata : cap_reg;

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (led_we)
        begin
            ledger_mem[led_waddr] <= led_wdata;
        end
        led_rdata <= ledger_mem[led_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            work_mem[wk_waddr] <= wk_wdata;
        end
        wk_rdata <= work_mem[wk_raddr];
    end

    // Ports.
    assign in_ch.ready   = (state_reg == ST_IDLE);
    assign out_ch.valid  = (state_reg == ST_EM_SEND);
    assign out_ch.payer  = MEMBER_W'(i_reg);
    assign out_ch.payee  = MEMBER_W'(j_reg);
    assign settle_wide   = {{SETTLE_W{1'b0}}, wk_rdata};
    assign out_ch.settle_amount = settle_wide[SETTLE_W-1:0];
    assign out_ch.last   = pair_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvalid_reg  <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            cell_reg    <= '0;
            visited_reg <= '0;
        end
        else
        begin
            lvalid_reg  <= lvalid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            cell_reg    <= cell_next;
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg    <= amt_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        pu_reg     <= pu_next;
        cap_reg    <= cap_next;
        bott_reg   <= bott_next;
        total_reg  <= total_next;
        parent_reg <= parent_next;
        qnode_reg  <= qnode_next;
        qcap_reg   <= qcap_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        lvalid_next  = lvalid_reg;
        cell_next    = cell_reg;
        amt_next     = amt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        pu_next      = pu_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cap_next     = cap_reg;
        bott_next    = bott_reg;
        total_next   = total_reg;
        visited_next = visited_reg;
        parent_next  = parent_reg;
        qnode_next   = qnode_reg;
        qcap_next    = qcap_reg;
        led_raddr    = cell_reg;
        led_waddr    = cell_reg;
        led_wdata    = '0;
        led_we       = 1'b0;
        wk_raddr     = cell_at(i_reg, j_reg);
        wk_waddr     = cell_reg;
        wk_wdata     = '0;
        wk_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.cmd == CMD_SIMPLIFY)
                    begin
                        cell_next  = '0;
                        state_next = ST_COPY_RD;
                    end
                    else if (({1'b0, in_ch.from_member} < (MEMBER_W + 1)'(MAX_MEMBERS)) &&
                             ({1'b0, in_ch.to_member} < (MEMBER_W + 1)'(MAX_MEMBERS)))
                    begin
                        cell_next  = cell_at(IDX_BITS'(in_ch.from_member),
                                             IDX_BITS'(in_ch.to_member));
                        amt_next   = in_ch.amount;
                        state_next = ST_ADD_RD;
                    end
                end
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                led_we = 1'b1;
                led_wdata = (led_sum > LSUM_W'(AMT_MAX)) ? AMT_MAX
                                                         : led_sum[AMOUNT_BITS-1:0];
                lvalid_next[cell_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                wk_we    = 1'b1;
                wk_wdata = led_cur;
                if (cell_reg == CELL_BITS'(CELLS - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_PAIR;
                end
                else
                begin
                    cell_next  = cell_reg + CELL_BITS'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_PAIR:
            begin
                if (i_reg == j_reg)
                begin
                    if (pair_end)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_EM_RD;
                    end
                    else if (j_reg == n_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_BITS'(1);
                    end
                end
                else
                begin
                    total_next = '0;
                    state_next = ST_BFS_INIT;
                end
            end
            ST_BFS_INIT:
            begin
                visited_next        = '0;
                visited_next[i_reg] = 1'b1;
                qnode_next[0]       = i_reg;
                qcap_next[0]        = AMT_MAX;
                head_next           = '0;
                tail_next           = CNT_BITS'(1);
                state_next          = ST_BFS_POP;
            end
            ST_BFS_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = ST_WR_TOTAL;
                end
                else
                begin
                    u_next     = qnode_reg[head_reg[IDX_BITS-1:0]];
                    cap_next   = qcap_reg[head_reg[IDX_BITS-1:0]];
                    head_next  = head_reg + CNT_BITS'(1);
                    k_next     = '0;
                    state_next = ST_BFS_RD;
                end
            end
            ST_BFS_RD:
            begin
                wk_raddr = cell_at(u_reg, kidx);
                if (k_reg >= n_eff)
                begin
                    state_next = ST_BFS_POP;
                end
                else if ((kidx == u_reg) || visited_reg[kidx])
                begin
                    k_next = k_reg + CNT_BITS'(1);
                end
                else
                begin
                    state_next = ST_BFS_CHK;
                end
            end
            ST_BFS_CHK:
            begin
                k_next     = k_reg + CNT_BITS'(1);
                state_next = ST_BFS_RD;
                if (wk_rdata != '0)
                begin
                    parent_next[kidx]  = u_reg;
                    visited_next[kidx] = 1'b1;
                    if (kidx == j_reg)
                    begin
                        // Path found: fold the bottleneck into the sum and walk back.
                        bott_next  = edge_min;
                        total_next = flow_sum[AMOUNT_BITS] ? AMT_MAX
                                                           : flow_sum[AMOUNT_BITS-1:0];
                        v_next     = j_reg;
                        state_next = ST_TR_RD;
                    end
                    else if (tail_reg < CNT_BITS'(MAX_MEMBERS))
                    begin
                        qnode_next[tail_reg[IDX_BITS-1:0]] = kidx;
                        qcap_next[tail_reg[IDX_BITS-1:0]]  = edge_min;
                        tail_next = tail_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_TR_RD:
            begin
                wk_raddr = cell_at(parent_reg[v_reg], v_reg);
                if (v_reg == i_reg)
                begin
                    state_next = ST_BFS_INIT;
                end
                else
                begin
                    pu_next    = parent_reg[v_reg];
                    state_next = ST_TR_WR;
                end
            end
            ST_TR_WR:
            begin
                wk_we      = 1'b1;
                wk_waddr   = cell_at(pu_reg, v_reg);
                wk_wdata   = wk_rdata - bott_reg;
                v_next     = pu_reg;
                state_next = ST_TR_RD;
            end
            ST_WR_TOTAL:
            begin
                wk_we    = 1'b1;
                wk_waddr = cell_at(i_reg, j_reg);
                wk_wdata = total_reg;
                if (pair_end)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    state_next = ST_PAIR;
                    if (j_reg == n_last)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_BITS'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_BITS'(1);
                    end
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_SEND;
            end
            ST_EM_SEND:
            begin
                // The read address stays on the current entry, so the word holds.
                if (out_ch.ready)
                begin
                    if (pair_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                        if (j_reg == n_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_BITS'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_BITS'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `DGMF_ASSERT_NEXT(a_last_ends, out_ch.valid && out_ch.ready && out_ch.last,
        state_reg == ST_IDLE, "emission did not end after the last word")
    `DGMF_ASSERT_NEXT(a_simplify_copies,
        in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_SIMPLIFY),
        state_reg == ST_COPY_RD, "simplify did not start the ledger copy")
    `DGMF_ASSERT_SAME(a_queue_order, state_reg != ST_IDLE, head_reg <= tail_reg,
        "search queue head passed its tail")
    `DGMF_ASSERT_SAME(a_path_cap, state_reg == ST_TR_WR,
        (wk_rdata >= bott_reg) && (bott_reg != '0), "path edge below its bottleneck")

endmodule
